// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the RTL. They compile away under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("assertion failed: condition does not hold");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication does not hold");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication does not hold");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/zrt_pkg.sv -----
// ----------------------------------------------------------------------------
// zrt_pkg
// Shared types and constants of the zigzag rail transposition block.
// ----------------------------------------------------------------------------
package zrt_pkg;

	localparam int CHAR_W = 8;
	localparam int ROWS_W = 7;
	// Rail period 2*(rows-1) needs one bit more than the row count.
	localparam int STEP_W = ROWS_W + 1;
	// Position plus step, and comparisons against the row count.
	localparam int SUM_W  = STEP_W + 1;
	localparam int CMP_W  = ROWS_W + 1;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Register index taken from the word address bit.
	localparam logic REG_NUM_ROWS = 1'b0;
	localparam logic [ROWS_W-1:0] NUM_ROWS_RESET = 7'd1;

	typedef enum logic {
		ST_LOAD,
		ST_READ
	} zrt_state_t;

	typedef struct packed {
		logic busy;
		logic last;
	} zrt_walk_st_t;

endpackage

// ----- hw/rtl/zrt_walk.sv -----
// ----------------------------------------------------------------------------
// zrt_walk
// Readout address sequencer: walks the stored positions rail by rail.
// ----------------------------------------------------------------------------
module zrt_walk #(
	parameter int AW      = 6,
	parameter int CW      = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [CW-1:0]               len,
	input  logic [zrt_pkg::ROWS_W-1:0]  rails,
	input  logic                        advance,
	output logic [AW-1:0]               addr,
	output zrt_pkg::zrt_walk_st_t       stat
);

	logic                        busy_q;
	logic                        phase_q;
	logic [AW-1:0]               pos_q;
	logic [AW-1:0]               rail_q;
	logic [CW-1:0]               len_q;
	logic [zrt_pkg::ROWS_W-1:0]  rails_q;
	logic [zrt_pkg::STEP_W-1:0]  period_q;

	logic [zrt_pkg::STEP_W-1:0]  two_r;
	logic [zrt_pkg::STEP_W-1:0]  step_raw;
	logic [zrt_pkg::STEP_W-1:0]  step;
	logic [zrt_pkg::SUM_W-1:0]   next_pos;
	logic [CW-1:0]               rail_nxt;
	logic                        rail_over;
	logic                        walk_end;

	// Inner rails alternate between the down leg (period - 2r) and the up leg (2r).
	// The top and bottom rails have one leg of zero, so they step by the full period.
	always_comb begin
		two_r    = zrt_pkg::STEP_W'({rail_q, 1'b0});
		step_raw = phase_q ? two_r : (period_q - two_r);
		if (step_raw != '0) begin
			step = step_raw;
		end else if (period_q != '0) begin
			step = period_q;
		end else begin
			step = zrt_pkg::STEP_W'(1);
		end
		next_pos  = zrt_pkg::SUM_W'(pos_q) + zrt_pkg::SUM_W'(step);
		rail_over = next_pos >= zrt_pkg::SUM_W'(len_q);
		rail_nxt  = CW'(rail_q) + CW'(1);
		walk_end  = rail_over &&
			((zrt_pkg::CMP_W'(rail_nxt) >= zrt_pkg::CMP_W'(rails_q)) || (rail_nxt >= len_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (advance && walk_end) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			pos_q    <= '0;
			rail_q   <= '0;
			phase_q  <= 1'b0;
			len_q    <= len;
			rails_q  <= rails;
			period_q <= {rails - zrt_pkg::ROWS_W'(1), 1'b0};
		end else if (advance) begin
			if (rail_over) begin
				rail_q  <= rail_nxt[AW-1:0];
				pos_q   <= rail_nxt[AW-1:0];
				phase_q <= 1'b0;
			end else begin
				pos_q   <= next_pos[AW-1:0];
				phase_q <= ~phase_q;
			end
		end
	end

	assign addr      = pos_q;
	assign stat.busy = busy_q;
	assign stat.last = busy_q && walk_end;

endmodule

// ----- hw/rtl/zigzag_rail_transpose.sv -----
// ----------------------------------------------------------------------------
// zigzag_rail_transpose
// Rail fence transposition: buffers one message, then reads it out rail by rail.
//
//   channel  signals                        direction  beat
//   input    in_valid in_stall in_char in_last   in     one character
//   output   out_valid out_stall out_char out_last out  one transposed character
//   config   psel penable pwrite paddr pwdata prdata pready  num_rows at 0x0
//
// Loading never stalls the input. The readout starts after the last character
// and delivers one beat per cycle from the single memory read port while
// out_stall is low; the first beat is read once the walk has started and is
// held in the read register.
// Input is stalled during the readout; out_stall holds the read sequencer.
// Reset takes effect at once; the character memory needs no clearing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module zigzag_rail_transpose #(
	parameter int MAX_LEN = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [zrt_pkg::CHAR_W-1:0]    in_char,
	input  logic                          in_last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [zrt_pkg::CHAR_W-1:0]    out_char,
	output logic                          out_last,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [zrt_pkg::PADDR_W-1:0]   paddr,
	input  logic [zrt_pkg::PDATA_W-1:0]   pwdata,
	output logic [zrt_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 1);

	zrt_pkg::zrt_state_t          state_q, state_nxt;
	logic [CW-1:0]                count_q;
	logic [zrt_pkg::ROWS_W-1:0]   num_rows_q;
	logic                         out_valid_q;
	logic                         out_last_q;
	logic [zrt_pkg::CHAR_W-1:0]   rd_data_q;
	logic [zrt_pkg::CHAR_W-1:0]   char_mem [MAX_LEN];

	logic                         in_acc;
	logic                         out_acc;
	logic                         full;
	logic                         start;
	logic                         issue;
	logic [CW-1:0]                msg_len;
	logic [zrt_pkg::ROWS_W-1:0]   rails;
	logic [AW-1:0]                rd_addr;
	zrt_pkg::zrt_walk_st_t        walk;
	logic                         reg_wr;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready && (paddr[2] == zrt_pkg::REG_NUM_ROWS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= zrt_pkg::NUM_ROWS_RESET;
		end else if (reg_wr) begin
			num_rows_q <= pwdata[zrt_pkg::ROWS_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == zrt_pkg::REG_NUM_ROWS) begin
			prdata = zrt_pkg::PDATA_W'(num_rows_q);
		end else begin
			prdata = '0;
		end
	end

	// ---------------- control ----------------
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;
	assign full    = (count_q == CW'(MAX_LEN));
	assign start   = in_acc && in_last;
	assign msg_len = full ? count_q : (count_q + CW'(1));
	assign rails   = (num_rows_q == '0) ? zrt_pkg::ROWS_W'(1) : num_rows_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			zrt_pkg::ST_LOAD: begin
				if (start) begin
					state_nxt = zrt_pkg::ST_READ;
				end
			end
			zrt_pkg::ST_READ: begin
				if (issue && walk.last) begin
					state_nxt = zrt_pkg::ST_LOAD;
				end
			end
			default: state_nxt = zrt_pkg::ST_LOAD;
		endcase
	end

	// In ST_READ, a busy walk reads when the output is empty or drains.
	always_comb begin
		in_stall = 1'b1;
		issue    = 1'b0;
		unique case (state_q)
			zrt_pkg::ST_LOAD: in_stall = 1'b0;
			zrt_pkg::ST_READ: issue = walk.busy && (!out_valid_q || !out_stall);
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= zrt_pkg::ST_LOAD;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (start) begin
				count_q <= '0;
			end else if (in_acc && !full) begin
				count_q <= count_q + CW'(1);
			end
			if (issue) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- character memory ----------------
	always_ff @(posedge clk) begin
		if (in_acc && !full) begin
			char_mem[count_q[AW-1:0]] <= in_char;
		end
	end

	// The read register doubles as the output register; it holds while stalled.
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_q  <= char_mem[rd_addr];
			out_last_q <= walk.last;
		end
	end

	zrt_walk #(
		.AW      (AW),
		.CW      (CW)
	) u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.len     (msg_len),
		.rails   (rails),
		.advance (issue),
		.addr    (rd_addr),
		.stat    (walk)
	);

	assign out_valid = out_valid_q;
	assign out_char  = rd_data_q;
	assign out_last  = out_last_q;

	// ---------------- assertions ----------------
	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(MAX_LEN))
	`ASSERT_IMP(a_walk_only_in_read, clk, arst_n, walk.busy, state_q == zrt_pkg::ST_READ)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid_q && out_stall, out_valid_q && $stable(out_char))

endmodule

// ----- bench/zigzag_rail_transpose_test.sv -----
// ----------------------------------------------------------------------------
// zigzag_rail_transpose_test
// Self-checking bench for the rail fence transposition block. Messages go in
// one character per beat. A predictor tracks the buffered message and the
// rail count, and queues the transposed beats that each message should give.
// Every output beat is compared with the oldest queued beat. A directed table
// runs first, then random messages under random stalls on both channels.
// ----------------------------------------------------------------------------
module zigzag_rail_transpose_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MSG_DEPTH   = 64;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 200;
	localparam int RAND_ITEMS  = 180;
	localparam logic [zrt_pkg::PADDR_W-1:0] ROWS_ADDR = {zrt_pkg::REG_NUM_ROWS, 2'b00};

	typedef struct packed {
		logic                       cfg_wr;
		logic [zrt_pkg::ROWS_W-1:0] cfg_val;
		logic [zrt_pkg::CHAR_W-1:0] ch;
		logic [7:0]                 cnt;
		logic                       last;
		logic                       typed;
		logic [zrt_pkg::CHAR_W-1:0] exp_char;
	} plan_row_t;

	typedef struct packed {
		logic [zrt_pkg::CHAR_W-1:0] ch;
		logic                       last;
	} rail_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [zrt_pkg::CHAR_W-1:0] in_char = '0;
	logic in_last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [zrt_pkg::CHAR_W-1:0] out_char;
	logic out_last;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [zrt_pkg::PADDR_W-1:0] paddr = '0;
	logic [zrt_pkg::PDATA_W-1:0] pwdata = '0;
	logic [zrt_pkg::PDATA_W-1:0] prdata;
	logic pready;

	// Side information for the beat on the input channel.
	logic drv_typed = 1'b0;
	logic [zrt_pkg::CHAR_W-1:0] drv_exp_char = '0;

	logic calm = 1'b0;
	logic hold_req = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;

	int fail_count = 0;
	int cycle_count = 0;

	// Predictor state.
	logic [zrt_pkg::CHAR_W-1:0] msg_mem [MSG_DEPTH];
	int msg_len = 0;
	logic [zrt_pkg::ROWS_W-1:0] rails_cfg = zrt_pkg::NUM_ROWS_RESET;
	rail_beat_t rail_beats_due [$];
	rail_beat_t due;

	plan_row_t plan [0:13] = '{
		'{1'b0, 7'd0,   8'h41, 8'd1,  1'b1, 1'b1, 8'h41},
		'{1'b0, 7'd0,   8'h00, 8'd1,  1'b1, 1'b1, 8'h00},
		'{1'b0, 7'd0,   8'hFF, 8'd1,  1'b1, 1'b1, 8'hFF},
		'{1'b0, 7'd0,   8'h48, 8'd5,  1'b1, 1'b0, 8'h00},
		'{1'b1, 7'd3,   8'h30, 8'd7,  1'b1, 1'b0, 8'h00},
		'{1'b1, 7'd2,   8'hA5, 8'd4,  1'b1, 1'b0, 8'h00},
		'{1'b1, 7'd0,   8'h61, 8'd3,  1'b1, 1'b0, 8'h00},
		'{1'b1, 7'd64,  8'h80, 8'd1,  1'b1, 1'b1, 8'h80},
		'{1'b0, 7'd0,   8'h01, 8'd5,  1'b1, 1'b0, 8'h00},
		'{1'b1, 7'd127, 8'h7C, 8'd4,  1'b1, 1'b0, 8'h00},
		'{1'b1, 7'd5,   8'h00, 8'd66, 1'b1, 1'b0, 8'h00},
		'{1'b1, 7'd2,   8'hC0, 8'd3,  1'b0, 1'b0, 8'h00},
		'{1'b1, 7'd4,   8'hC3, 8'd3,  1'b1, 1'b0, 8'h00},
		'{1'b1, 7'd64,  8'hF0, 8'd64, 1'b1, 1'b0, 8'h00}
	};

	logic [zrt_pkg::ROWS_W-1:0] rows_pick [8] =
		'{7'd2, 7'd1, 7'd64, 7'd0, 7'd3, 7'd127, 7'd6, 7'd65};

	zigzag_rail_transpose #(
		.MAX_LEN(MSG_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_char(in_char),
		.in_last(in_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.out_last(out_last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int rail_of_pos(input int pos, input int rails);
		int period;
		int m;
		if (rails <= 1) return 0;
		period = 2 * (rails - 1);
		m = pos % period;
		return (m < rails) ? m : period - m;
	endfunction

	// Buffers one character; on the last one, queues the message rail by rail (or one typed beat).
	task automatic take_char(input logic [zrt_pkg::CHAR_W-1:0] ch, input logic last,
			input logic typed, input logic [zrt_pkg::CHAR_W-1:0] typed_char);
		int rails;
		int emitted;
		rail_beat_t b;
		if (msg_len < MSG_DEPTH) begin
			msg_mem[msg_len] = ch;
			msg_len++;
		end
		if (last) begin
			rails = (rails_cfg == 0) ? 1 : int'(rails_cfg);
			if (typed) begin
				b.ch = typed_char;
				b.last = 1'b1;
				rail_beats_due.push_back(b);
			end else begin
				emitted = 0;
				// Every position lands on exactly one rail, so n beats come out.
				for (int r = 0; r < rails && r < msg_len; r++) begin
					for (int j = 0; j < msg_len; j++) begin
						if (rail_of_pos(j, rails) == r) begin
							b.ch = msg_mem[j];
							b.last = (emitted == msg_len - 1);
							rail_beats_due.push_back(b);
							emitted++;
						end
					end
				end
			end
			msg_len = 0;
		end
	endtask

	task automatic send_char(input logic [zrt_pkg::CHAR_W-1:0] ch, input logic last,
			input logic typed, input logic [zrt_pkg::CHAR_W-1:0] typed_char);
		while (!calm && $urandom_range(0, 99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_char <= ch;
		in_last <= last;
		drv_typed <= typed;
		drv_exp_char <= typed_char;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	// Stops the input channel and waits until the block has drained.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (rail_beats_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_rows(input logic [zrt_pkg::ROWS_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ROWS_ADDR;
		pwdata <= zrt_pkg::PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rails_cfg = v;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== zrt_pkg::PDATA_W'(v)) begin
			$error("num_rows readback: expected %0d, got %0d", v, prdata);
			fail_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		int items_sent;
		int msg_idx;
		int phase;
		int len;
		int pick;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].cfg_wr) begin
				settle();
				write_rows(plan[i].cfg_val);
			end
			for (int k = 0; k < plan[i].cnt; k++)
				send_char(8'(plan[i].ch + k), plan[i].last && (k == plan[i].cnt - 1),
					plan[i].typed, plan[i].exp_char);
		end

		items_sent = 0;
		msg_idx = 0;
		phase = 0;
		while (items_sent < RAND_ITEMS) begin
			if (msg_idx % 2 == 0) begin
				settle();
				write_rows((phase < 8) ? rows_pick[phase] :
					zrt_pkg::ROWS_W'($urandom_range(0, 127)));
				phase++;
				// The receiver holds off while the next messages keep coming.
				if (msg_idx == 4) hold_req <= 1'b1;
			end
			calm <= (msg_idx >= 8 && msg_idx < 14);
			pick = $urandom_range(0, 99);
			if (pick < 75) len = $urandom_range(1, 10);
			else if (pick < 93) len = $urandom_range(11, 64);
			else len = $urandom_range(65, 70);
			for (int k = 0; k < len; k++)
				send_char(zrt_pkg::CHAR_W'($urandom_range(0, 255)), k == len - 1, 1'b0, '0);
			items_sent += len;
			msg_idx++;
		end

		settle();
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(0, 99) < 37);
		end
	end

	// Outputs are checked before the input beat of the same edge is predicted.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (rail_beats_due.size() == 0) begin
				$error("out_char: expected no beat, got %02h", out_char);
				fail_count++;
			end else begin
				due = rail_beats_due.pop_front();
				if (out_char !== due.ch) begin
					$error("out_char: expected %02h, got %02h", due.ch, out_char);
					fail_count++;
				end
				if (out_last !== due.last) begin
					$error("out_last: expected %0b, got %0b", due.last, out_last);
					fail_count++;
				end
			end
		end
		if (arst_n && in_valid && !in_stall)
			take_char(in_char, in_last, drv_typed, drv_exp_char);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule
